// ===== sv/cfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the CFL time-step reduction block.
// Holds the sequencer state type, register indexes and format constants; no dependencies.
package cfl_pkg;

    localparam int unsigned QW      = 32;
    localparam int unsigned CFG_IW  = 3;
    localparam logic [QW-1:0] Q_ONES = '1;

    // Step counts of the shared shift-subtract unit.
    localparam logic [6:0] SQRT_STEPS  = 7'd32;
    localparam logic [6:0] SPEED_STEPS = 7'd48;
    localparam logic [6:0] STEP_STEPS  = 7'd64;

    localparam logic [CFG_IW-1:0] REG_COURANT = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CELL    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DRY     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GRAVITY = 3'd3;
    localparam logic [CFG_IW-1:0] REG_TTO     = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SQRT = 7'b0000100,
        S_DIVF = 7'b0001000,
        S_PREP = 7'b0010000,
        S_DIVS = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

// ===== sv/cfl_time_step_reduction_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// CFL time-step reduction top level around one shared shift-subtract unit; depends on cfl_pkg.
// Sequence: a dry cell goes from the input transfer straight to the output register; a wet cell
// runs a multiply, 32 root steps, 48 speed steps, a prepare, 64 step-division steps and the output.
// Throughput: one cell at a time; the input is ready again once the result register loads, so a
// result held by a stalled receiver keeps the next cell waiting.
// Reset (rst_n, asynchronous, active low) restores register defaults and resets both sweep accumulators.
module cfl_time_step_reduction_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] depth,
    input  wire logic signed [31:0] flow_x,
    input  wire logic signed [31:0] flow_y,
    input  wire logic        last_cell,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             cell_dry,
    output logic             sweep_done,
    output logic [31:0]      stable_step,
    output logic [31:0]      max_wet_depth
);

    // Configuration registers. Writes are accepted in every cycle.
    logic [31:0] courant_reg, cell_reg, dry_reg, gravity_reg, tto_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            courant_reg <= 32'd65536;
            cell_reg    <= 32'd65536;
            dry_reg     <= 32'd0;
            gravity_reg <= 32'd642908;
            tto_reg     <= cfl_pkg::Q_ONES;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cfl_pkg::REG_COURANT: courant_reg <= cfg_data;
                cfl_pkg::REG_CELL:    cell_reg    <= cfg_data;
                cfl_pkg::REG_DRY:     dry_reg     <= cfg_data;
                cfl_pkg::REG_GRAVITY: gravity_reg <= cfg_data;
                cfl_pkg::REG_TTO:     tto_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and shared datapath registers.
    cfl_pkg::state_t state_reg, state_next;
    logic [31:0] depth_reg;     // depth of the cell in work
    logic [31:0] mag_reg;       // larger of the two discharge magnitudes
    logic        last_reg;
    logic        dry_cell_reg;  // dry flag of the cell in work
    logic [63:0] dvd_reg;       // dividend or radicand, consumed from the top
    logic [34:0] rem_reg;       // partial remainder
    logic [31:0] q_reg;         // quotient or root under construction
    logic        ovf_reg;       // quotient went past 32 bits
    logic [32:0] den_reg;       // divisor
    logic [31:0] wave_reg;      // wave speed sqrt(g*h)
    logic [31:0] step_reg;      // step of this cell, all ones for a dry cell
    logic [6:0]  cnt_reg;
    logic [31:0] min_step_reg, max_depth_reg;
    logic        out_valid_reg;

    // Input magnitudes. Negating 0x80000000 gives 0x80000000, the right magnitude.
    logic [31:0] mag_x, mag_y;
    assign mag_x = flow_x[31] ? (~flow_x + 32'd1) : flow_x;
    assign mag_y = flow_y[31] ? (~flow_y + 32'd1) : flow_y;

    // The single multiplier: gravity*depth for the wave speed, then courant*cell_size.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_a = (state_reg == cfl_pkg::S_MUL) ? gravity_reg : courant_reg;
    assign mul_b = (state_reg == cfl_pkg::S_MUL) ? depth_reg   : cell_reg;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // Shared shift-subtract step. Square root brings in two radicand bits per step and
    // tries 4*root+1; division brings in one dividend bit and tries the divisor.
    logic        sqrt_mode;
    logic [34:0] shifted, trial, diff;
    logic        ge;
    logic [34:0] rem_step;
    logic [31:0] q_step;
    logic [63:0] dvd_step;

    assign sqrt_mode = (state_reg == cfl_pkg::S_SQRT);
    assign shifted   = sqrt_mode ? {rem_reg[32:0], dvd_reg[63:62]} : {rem_reg[33:0], dvd_reg[63]};
    assign trial     = sqrt_mode ? {1'b0, q_reg, 2'b01} : {2'b00, den_reg};
    assign ge        = (shifted >= trial);
    assign diff      = shifted - trial;
    assign rem_step  = ge ? diff : shifted;
    assign q_step    = {q_reg[30:0], ge};
    assign dvd_step  = sqrt_mode ? {dvd_reg[61:0], 2'b00} : {dvd_reg[62:0], 1'b0};

    // Speed after saturation and the one-LSB floor.
    logic [31:0] speed_sat;
    assign speed_sat = ovf_reg ? cfl_pkg::Q_ONES : ((q_reg == 32'd0) ? 32'd1 : q_reg);

    // Step of the cell from the last step-division cycle, saturated.
    logic [31:0] step_sat;
    assign step_sat = (ovf_reg || q_reg[31]) ? cfl_pkg::Q_ONES : q_step;

    // Accumulators including the current cell, used when the result is formed.
    logic [31:0] min_with_cell, max_with_cell, capped;
    assign min_with_cell = (step_reg < min_step_reg) ? step_reg : min_step_reg;
    assign max_with_cell = (!dry_cell_reg && depth_reg > max_depth_reg) ? depth_reg
                                                                        : max_depth_reg;
    assign capped        = (min_with_cell < tto_reg) ? min_with_cell : tto_reg;

    logic out_free;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == cfl_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfl_pkg::S_IDLE: if (in_valid) state_next = (depth <= dry_reg) ?
                                                         cfl_pkg::S_DONE : cfl_pkg::S_MUL;
            cfl_pkg::S_MUL:  state_next = cfl_pkg::S_SQRT;
            cfl_pkg::S_SQRT: if (cnt_reg == 7'd1) state_next = cfl_pkg::S_DIVF;
            cfl_pkg::S_DIVF: if (cnt_reg == 7'd1) state_next = cfl_pkg::S_PREP;
            cfl_pkg::S_PREP: state_next = cfl_pkg::S_DIVS;
            cfl_pkg::S_DIVS: if (cnt_reg == 7'd1) state_next = cfl_pkg::S_DONE;
            cfl_pkg::S_DONE: if (out_free) state_next = cfl_pkg::S_IDLE;
            default:         state_next = cfl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfl_pkg::S_IDLE;
            cnt_reg       <= 7'd0;
            min_step_reg  <= cfl_pkg::Q_ONES;
            max_depth_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cfl_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                cfl_pkg::S_MUL:  cnt_reg <= cfl_pkg::SQRT_STEPS;
                cfl_pkg::S_SQRT: cnt_reg <= (cnt_reg == 7'd1) ? cfl_pkg::SPEED_STEPS
                                                              : cnt_reg - 7'd1;
                cfl_pkg::S_DIVF: cnt_reg <= cnt_reg - 7'd1;
                cfl_pkg::S_PREP: cnt_reg <= cfl_pkg::STEP_STEPS;
                cfl_pkg::S_DIVS: cnt_reg <= cnt_reg - 7'd1;
                cfl_pkg::S_DONE:
                begin
                    if (out_free)
                    begin
                        if (last_reg)
                        begin
                            min_step_reg  <= cfl_pkg::Q_ONES;
                            max_depth_reg <= 32'd0;
                        end
                        else
                        begin
                            min_step_reg  <= min_with_cell;
                            max_depth_reg <= max_with_cell;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cfl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    depth_reg    <= depth;
                    mag_reg      <= (mag_x > mag_y) ? mag_x : mag_y;
                    last_reg     <= last_cell;
                    dry_cell_reg <= (depth <= dry_reg);
                    step_reg     <= cfl_pkg::Q_ONES;
                end
            end
            cfl_pkg::S_MUL:
            begin
                dvd_reg <= mul_p;
                rem_reg <= 35'd0;
                q_reg   <= 32'd0;
                ovf_reg <= 1'b0;
            end
            cfl_pkg::S_SQRT:
            begin
                if (cnt_reg == 7'd1)
                begin
                    // Root complete: set up |flow| << 16 divided by depth.
                    wave_reg <= q_step;
                    dvd_reg  <= {mag_reg, 32'd0};
                    den_reg  <= {1'b0, depth_reg};
                    rem_reg  <= 35'd0;
                    q_reg    <= 32'd0;
                    ovf_reg  <= 1'b0;
                end
                else
                begin
                    rem_reg <= rem_step;
                    q_reg   <= q_step;
                    dvd_reg <= dvd_step;
                end
            end
            cfl_pkg::S_DIVF:
            begin
                rem_reg <= rem_step;
                q_reg   <= q_step;
                dvd_reg <= dvd_step;
                ovf_reg <= ovf_reg | q_reg[31];
            end
            cfl_pkg::S_DIVS:
            begin
                rem_reg <= rem_step;
                q_reg   <= q_step;
                dvd_reg <= dvd_step;
                ovf_reg <= ovf_reg | q_reg[31];
                // The last division cycle hands the finished step to DONE.
                if (cnt_reg == 7'd1)
                begin
                    step_reg <= step_sat;
                end
            end
            cfl_pkg::S_PREP:
            begin
                // The larger speed gives the smaller step, so one division covers both.
                den_reg <= {1'b0, speed_sat} + {1'b0, wave_reg};
                dvd_reg <= mul_p;
                rem_reg <= 35'd0;
                q_reg   <= 32'd0;
                ovf_reg <= 1'b0;
            end
            cfl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cell_dry      <= dry_cell_reg;
                    sweep_done    <= last_reg;
                    stable_step   <= last_reg ? capped : 32'd0;
                    max_wet_depth <= last_reg ? max_with_cell : 32'd0;
                end
            end
            default: ;
        endcase
    end

    // Assertions.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state not one-hot");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfl_pkg::S_DIVS) |-> (den_reg != 33'd0))
        else $error("zero divisor in step division");
    a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !sweep_done) |-> (stable_step == 32'd0 && max_wet_depth == 32'd0))
        else $error("non-final result carries sweep data");

endmodule
`default_nettype wire

// ===== verif/cfl_time_step_reduction_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the CFL time-step reduction block.
// A local predictor computes the expected result for every cell transfer.
// Depends on cfl_pkg and cfl_time_step_reduction_top.
module cfl_time_step_reduction_top_tb;

    typedef struct packed {
        logic        dry;
        logic        done;
        logic [31:0] step;
        logic [31:0] max_depth;
    } cell_result_t;

    typedef struct packed {
        logic [31:0]        depth;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               last;
    } cell_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = cfl_pkg::REG_COURANT;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] depth = '0;
    logic signed [31:0] flow_x = '0;
    logic signed [31:0] flow_y = '0;
    logic        last_cell = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        cell_dry;
    logic        sweep_done;
    logic [31:0] stable_step;
    logic [31:0] max_wet_depth;

    // Shadow copy of the configuration and the sweep accumulators.
    logic [31:0] m_courant, m_cell, m_dry, m_gravity, m_tto;
    logic [31:0] m_min_step, m_max_depth;

    cell_result_t pending_results[$];
    int unsigned  mismatches = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    bit           hold_output = 1'b0;

    always #4 clk = ~clk;

    cfl_time_step_reduction_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .depth(depth), .flow_x(flow_x), .flow_y(flow_y), .last_cell(last_cell),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_dry(cell_dry), .sweep_done(sweep_done),
        .stable_step(stable_step), .max_wet_depth(max_wet_depth)
    );

    // ---------------------------------------------------------------- predictor

    // Bitwise integer square root of a 64-bit value.
    function automatic logic [31:0] int_sqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] sat_q(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? cfl_pkg::Q_ONES : v[31:0];
    endfunction

    // Flow speed |flow/depth| in Q16.16, saturated and floored at one LSB.
    function automatic logic [31:0] flow_speed(input logic signed [31:0] f,
                                               input logic [31:0] d);
        logic [63:0] mag;
        logic [31:0] s;
        mag = f[31] ? (64'h1_0000_0000 - {32'd0, f}) : {32'd0, f};
        s   = sat_q((mag << 16) / {32'd0, d});
        return (s == 0) ? 32'd1 : s;
    endfunction

    function automatic logic [31:0] courant_step(input logic [31:0] speed,
                                                 input logic [31:0] wave);
        logic [63:0] num;
        logic [63:0] den;
        num = {32'd0, m_courant} * {32'd0, m_cell};
        den = {32'd0, speed} + {32'd0, wave};
        return sat_q(num / den);
    endfunction

    function automatic cell_result_t predict_cell(input cell_t c);
        cell_result_t r;
        logic [31:0]  wave, su, sv, s;
        r.dry = (c.depth <= m_dry);
        if (!r.dry)
        begin
            wave = int_sqrt64({32'd0, m_gravity} * {32'd0, c.depth});
            su   = courant_step(flow_speed(c.fx, c.depth), wave);
            sv   = courant_step(flow_speed(c.fy, c.depth), wave);
            s    = (su < sv) ? su : sv;
            if (s < m_min_step)
                m_min_step = s;
            if (c.depth > m_max_depth)
                m_max_depth = c.depth;
        end
        r.done = c.last;
        if (c.last)
        begin
            r.step      = (m_min_step < m_tto) ? m_min_step : m_tto;
            r.max_depth = m_max_depth;
            m_min_step  = cfl_pkg::Q_ONES;
            m_max_depth = '0;
        end
        else
        begin
            r.step      = '0;
            r.max_depth = '0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Sends one cell. Valid is only lowered when an idle cycle is inserted, so a
    // back-to-back cell never sees valid dropped and raised within one step.
    task automatic send_cell(input cell_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        depth     <= c.depth;
        flow_x    <= c.fx;
        flow_y    <= c.fy;
        last_cell <= c.last;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_cell(c));
    endtask

    task automatic send_fields(input logic [31:0] d, input logic [31:0] fx,
                               input logic [31:0] fy, input logic last);
        cell_t c;
        c.depth = d;
        c.fx    = fx;
        c.fy    = fy;
        c.last  = last;
        send_cell(c);
    endtask

    // Waits until every expected result has arrived, plus the wet-cell latency.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cfl_pkg::REG_COURANT: m_courant = value;
            cfl_pkg::REG_CELL:    m_cell    = value;
            cfl_pkg::REG_DRY:     m_dry     = value;
            cfl_pkg::REG_GRAVITY: m_gravity = value;
            cfl_pkg::REG_TTO:     m_tto     = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] cn, input logic [31:0] cs,
                            input logic [31:0] dd, input logic [31:0] g,
                            input logic [31:0] tto);
        drain_results();
        write_reg(cfl_pkg::REG_COURANT, cn);
        write_reg(cfl_pkg::REG_CELL, cs);
        write_reg(cfl_pkg::REG_DRY, dd);
        write_reg(cfl_pkg::REG_GRAVITY, g);
        write_reg(cfl_pkg::REG_TTO, tto);
    endtask

    // Receiver: random stalls, or a long hold-off while hold_output is set.
    always @(posedge clk)
        out_ready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (cell_dry !== want.dry)
                    report_mismatch("cell_dry", cell_dry, want.dry);
                if (sweep_done !== want.done)
                    report_mismatch("sweep_done", sweep_done, want.done);
                if (stable_step !== want.step)
                    report_mismatch("stable_step", stable_step, want.step);
                if (max_wet_depth !== want.max_depth)
                    report_mismatch("max_wet_depth", max_wet_depth, want.max_depth);
            end
        end
    end

    // ---------------------------------------------------------------- random content

    function automatic logic [31:0] rand_depth();
        case ($urandom_range(4))
            0: return $urandom_range(32'h3_FFFF);
            1: return $urandom();
            2: return m_dry + $urandom_range(3) - 1;
            3: return $urandom_range(32'hFF_FFFF);
            default: return $urandom_range(32'h1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_flow();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h7_FFFF) - 32'h4_0000;
            2: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(255);
            default: return $urandom_range(32'hFFFF);
        endcase
    endfunction

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h10_0000);
            2: return $urandom_range(1) ? 32'h0 : cfl_pkg::Q_ONES;
            default: return 32'h1_0000;
        endcase
    endfunction

    // Random sweeps of one to twelve cells, each ending in a last cell.
    task automatic run_sweeps(input int unsigned n_cells);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_cells)
        begin
            len = $urandom_range(12, 1);
            for (int unsigned i = 0; i < len; i++)
                send_fields(rand_depth(), rand_flow(), rand_flow(), i == len - 1);
            sent += len;
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Default registers: dry cells, extreme depths and flows, all-dry sweep.
    task automatic test_defaults();
        send_fields(32'h0, 32'h0, 32'h0, 1'b1);                 // all-dry sweep
        send_fields(32'h1, 32'h0, 32'h0, 1'b0);                 // zero flows
        send_fields(cfl_pkg::Q_ONES, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_fields(32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0); // speed saturates
        send_fields(32'h2_0000, 32'hFFFF_FFFF, 32'h1_0000, 1'b1);
        send_fields(32'h1_0000, 32'h0, 32'h0, 1'b0);
        send_fields(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // dry cell ends sweep
    endtask

    // Register extremes: zero numerator, zero wave speed, saturated step, caps.
    task automatic test_register_extremes();
        set_regs(32'h0, cfl_pkg::Q_ONES, 32'h0, 32'h9_CF5C, cfl_pkg::Q_ONES); // zero courant
        send_fields(32'h1_0000, 32'h1234, 32'h0, 1'b1);
        set_regs(cfl_pkg::Q_ONES, cfl_pkg::Q_ONES, 32'h0, 32'h0, cfl_pkg::Q_ONES); // huge step
        send_fields(32'h1_0000, 32'h0, 32'h0, 1'b0);
        send_fields(cfl_pkg::Q_ONES, 32'h0, 32'h0, 1'b1);
        set_regs(32'h1_0000, 32'h0, 32'h0, cfl_pkg::Q_ONES, 32'h0); // zero cell size and cap
        send_fields(cfl_pkg::Q_ONES, 32'h7FFF_FFFF, 32'h8000_0001, 1'b1);
        set_regs(32'h8000, 32'hA_0000, cfl_pkg::Q_ONES, cfl_pkg::Q_ONES, 32'h5); // all dry
        send_fields(cfl_pkg::Q_ONES, 32'h1, 32'h1, 1'b0);
        send_fields(32'h0, 32'h1, 32'h1, 1'b1);
        set_regs(32'h1_0000, 32'h1_0000, 32'h8000, cfl_pkg::Q_ONES, 32'h100);
        send_fields(32'h8000, 32'h0, 32'h0, 1'b0);              // exactly at threshold
        send_fields(32'h8001, 32'h10, 32'hFFFF_FFF0, 1'b1);
    endtask

    task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                     input int unsigned n_cells);
        set_regs(rand_reg(), rand_reg(), $urandom_range(32'h1_0000), rand_reg(), rand_reg());
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        run_sweeps(n_cells / 2);
        set_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(), $urandom());
        run_sweeps(n_cells / 2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // The receiver holds off for a long stretch while cells keep being offered,
    // so the output register fills and the input stalls.
    task automatic test_backpressure();
        drain_results();
        fork
            begin
                hold_output = 1'b1;
                repeat (1500) @(posedge clk);
                hold_output = 1'b0;
            end
            run_sweeps(20);
        join
    endtask

    // The sender pauses mid-sweep until every result is back, then finishes the sweep.
    task automatic test_sender_pause();
        send_fields(32'h3_0000, 32'h2_0000, 32'hFFFE_0000, 1'b0);
        drain_results();
        send_fields(32'h1_8000, 32'h0, 32'h100, 1'b1);
    endtask

    initial
    begin
        m_courant   = 32'h1_0000;
        m_cell      = 32'h1_0000;
        m_dry       = 32'h0;
        m_gravity   = 32'd642908;
        m_tto       = cfl_pkg::Q_ONES;
        m_min_step  = cfl_pkg::Q_ONES;
        m_max_depth = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_register_extremes();
        test_random_phase(0, 0, 480);
        test_random_phase(51, 0, 480);
        test_random_phase(0, 51, 480);
        test_random_phase(15, 15, 480);
        test_backpressure();
        test_sender_pause();

        drain_results();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
